/* hw/rtl/dcd_pkg.sv */
package dcd_pkg;

  localparam int CHUNK_MAX = 1024;
  localparam int SAMPLE_W  = 16;
  localparam int TIME_W    = 32;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int LEN_W     = $clog2(CHUNK_MAX + 1);
  localparam int SQ_W      = 2 * SAMPLE_W;
  localparam int ENERGY_W  = SQ_W + LEN_W;

  localparam logic [CFG_W-1:0] RMS_THRESHOLD_RST = CFG_W'(1000);
  localparam logic [CFG_W-1:0] MAX_PEAK_MS_RST   = CFG_W'(100);
  localparam logic [CFG_W-1:0] WINDOW_MS_RST     = CFG_W'(600);
  localparam logic [CFG_W-1:0] MIN_GAP_MS_RST    = CFG_W'(100);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RMS_THRESHOLD = 2'd0,
    REG_MAX_PEAK_MS   = 2'd1,
    REG_WINDOW_MS     = 2'd2,
    REG_MIN_GAP_MS    = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [CFG_W-1:0] max_peak_ms;
    logic [CFG_W-1:0] window_ms;
    logic [CFG_W-1:0] min_gap_ms;
  } timing_t;

  typedef struct packed {
    logic                clear;
    logic [TIME_W-1:0]   now_ms;
    logic [ENERGY_W-1:0] energy;
    logic [ENERGY_W-1:0] limit;
  } chunk_t;

endpackage

/* hw/rtl/dcd_sample_if.sv */
interface dcd_sample_if;
  logic                              valid;
  logic                              ready;
  logic                              command;
  logic signed [dcd_pkg::SAMPLE_W-1:0] sample;
  logic                              chunk_end;
  logic [dcd_pkg::TIME_W-1:0]        now_ms;

  modport source (output valid, command, sample, chunk_end, now_ms, input ready);
  modport sink (input valid, command, sample, chunk_end, now_ms, output ready);
endinterface

/* hw/rtl/dcd_result_if.sv */
interface dcd_result_if;
  logic valid;
  logic ready;
  logic clap_detected;
  logic chunk_loud;

  modport source (output valid, clap_detected, chunk_loud, input ready);
  modport sink (input valid, clap_detected, chunk_loud, output ready);
endinterface

/* hw/rtl/dcd_cfg_if.sv */
interface dcd_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [dcd_pkg::CFG_IDX_W-1:0]  index;
  logic [dcd_pkg::CFG_W-1:0]      data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* hw/rtl/dcd_energy.sv */
module dcd_energy (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               command,
  input  logic signed [dcd_pkg::SAMPLE_W-1:0] sample,
  input  logic                               chunk_end,
  input  logic [dcd_pkg::TIME_W-1:0]         now_ms,
  input  logic [dcd_pkg::CFG_W-1:0]          rms_threshold,
  output logic                               chunk_valid,
  input  logic                               chunk_ready,
  output dcd_pkg::chunk_t                    chunk
);

  logic                               s1_valid;
  logic                               s1_cmd;
  logic signed [dcd_pkg::SAMPLE_W-1:0] s1_sample;
  logic                               s1_end;
  logic [dcd_pkg::TIME_W-1:0]         s1_now;

  logic                               s2_valid;
  logic                               s2_cmd;
  logic [dcd_pkg::SQ_W-1:0]           s2_sq;
  logic                               s2_end;
  logic [dcd_pkg::TIME_W-1:0]         s2_now;

  logic [dcd_pkg::ENERGY_W-1:0]       energy;
  logic [dcd_pkg::LEN_W-1:0]          len;

  logic                               s3_valid;
  logic                               s3_cmd;
  logic [dcd_pkg::TIME_W-1:0]         s3_now;
  logic [dcd_pkg::ENERGY_W-1:0]       s3_energy;
  logic [dcd_pkg::LEN_W-1:0]          s3_len;

  logic                               s4_valid;
  dcd_pkg::chunk_t                    s4;

  logic [dcd_pkg::SQ_W-1:0]           thr_sq;

  logic                               r2, r3, r4;
  logic [dcd_pkg::SAMPLE_W-1:0]       mag;
  logic                               sat;
  logic [dcd_pkg::ENERGY_W-1:0]       energy_next;
  logic [dcd_pkg::LEN_W-1:0]          len_next;

  assign r4       = !s4_valid || chunk_ready;
  assign r3       = !s3_valid || r4;
  assign r2       = !s2_valid || r3;
  assign in_ready = !s1_valid || r2;

  assign mag = s1_sample[dcd_pkg::SAMPLE_W-1] ? dcd_pkg::SAMPLE_W'(-s1_sample)
                                              : dcd_pkg::SAMPLE_W'(s1_sample);

  assign sat         = len >= dcd_pkg::LEN_W'(dcd_pkg::CHUNK_MAX);
  assign energy_next = sat ? energy : energy + dcd_pkg::ENERGY_W'(s2_sq);
  assign len_next    = sat ? len : len + dcd_pkg::LEN_W'(1);

  assign chunk_valid = s4_valid;
  assign chunk       = s4;

  always_ff @(posedge clk) begin
    thr_sq <= dcd_pkg::SQ_W'(rms_threshold) * dcd_pkg::SQ_W'(rms_threshold);

    if (in_ready) begin
      s1_cmd    <= command;
      s1_sample <= sample;
      s1_end    <= chunk_end;
      s1_now    <= now_ms;
    end

    if (r2) begin
      s2_cmd <= s1_cmd;
      s2_sq  <= dcd_pkg::SQ_W'(mag) * dcd_pkg::SQ_W'(mag);
      s2_end <= s1_end;
      s2_now <= s1_now;
    end

    if (r3) begin
      s3_cmd    <= s2_cmd;
      s3_now    <= s2_now;
      s3_energy <= energy_next;
      s3_len    <= len_next;
    end

    if (r4) begin
      s4.clear  <= s3_cmd;
      s4.now_ms <= s3_now;
      s4.energy <= s3_energy;
      s4.limit  <= dcd_pkg::ENERGY_W'(thr_sq) * dcd_pkg::ENERGY_W'(s3_len);
    end

    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      energy   <= '0;
      len      <= '0;
    end else begin
      if (in_ready) s1_valid <= in_valid;
      if (r2) s2_valid <= s1_valid;
      if (r3) s3_valid <= s2_valid && (s2_cmd || s2_end);
      if (r4) s4_valid <= s3_valid;
      if (s2_valid && r3) begin
        if (s2_cmd || s2_end) begin
          energy <= '0;
          len    <= '0;
        end else begin
          energy <= energy_next;
          len    <= len_next;
        end
      end
    end
  end

endmodule

/* hw/rtl/dcd_burst.sv */
module dcd_burst (
  input  logic                       clk,
  input  logic                       rst,
  input  dcd_pkg::timing_t           timing,
  input  logic                       chunk_valid,
  output logic                       chunk_ready,
  input  dcd_pkg::chunk_t            chunk,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       clap_detected,
  output logic                       chunk_loud
);

  logic                       in_burst;
  logic                       burst_void;
  logic                       awaiting_second;
  logic [dcd_pkg::TIME_W-1:0] burst_start_time;
  logic [dcd_pkg::TIME_W-1:0] first_clap_time;

  logic                       in_burst_next;
  logic                       burst_void_next;
  logic                       awaiting_next;
  logic [dcd_pkg::TIME_W-1:0] burst_start_next;
  logic [dcd_pkg::TIME_W-1:0] first_clap_next;
  logic                       clap_next;

  logic                       go;
  logic                       loud;
  logic [dcd_pkg::TIME_W-1:0] first_age;
  logic [dcd_pkg::TIME_W-1:0] burst_age;
  logic [dcd_pkg::TIME_W-1:0] gap;
  logic [dcd_pkg::TIME_W-1:0] max_peak;
  logic [dcd_pkg::TIME_W-1:0] window;
  logic [dcd_pkg::TIME_W-1:0] min_gap;
  logic                       awaiting_live;
  logic                       too_long;

  assign chunk_ready = chunk.clear || !out_valid || out_ready;
  assign go          = chunk_valid && chunk_ready;

  assign max_peak  = dcd_pkg::TIME_W'(timing.max_peak_ms);
  assign window    = dcd_pkg::TIME_W'(timing.window_ms);
  assign min_gap   = dcd_pkg::TIME_W'(timing.min_gap_ms);

  assign loud          = chunk.energy > chunk.limit;
  assign first_age     = chunk.now_ms - first_clap_time;
  assign burst_age     = chunk.now_ms - burst_start_time;
  assign gap           = burst_start_time - first_clap_time;
  assign awaiting_live = awaiting_second && !(first_age > window);
  assign too_long      = burst_age > max_peak;

  always_comb begin
    in_burst_next    = in_burst;
    burst_void_next  = burst_void;
    awaiting_next    = awaiting_live;
    burst_start_next = burst_start_time;
    first_clap_next  = first_clap_time;
    clap_next        = 1'b0;
    if (loud) begin
      if (!in_burst) begin
        in_burst_next    = 1'b1;
        burst_void_next  = 1'b0;
        burst_start_next = chunk.now_ms;
      end else if (!burst_void && too_long) begin
        burst_void_next = 1'b1;
      end
    end else if (in_burst) begin
      in_burst_next = 1'b0;
      if (!(burst_void || too_long)) begin
        if (!awaiting_live) begin
          first_clap_next = burst_start_time;
          awaiting_next   = 1'b1;
        end else begin
          clap_next     = (gap >= min_gap) && (gap <= window);
          awaiting_next = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_burst         <= 1'b0;
      burst_void       <= 1'b0;
      awaiting_second  <= 1'b0;
      burst_start_time <= '0;
      first_clap_time  <= '0;
      out_valid        <= 1'b0;
    end else begin
      out_valid <= (go && !chunk.clear) || (out_valid && !out_ready);
      if (go) begin
        if (chunk.clear) begin
          in_burst         <= 1'b0;
          burst_void       <= 1'b0;
          awaiting_second  <= 1'b0;
          burst_start_time <= '0;
          first_clap_time  <= '0;
        end else begin
          in_burst         <= in_burst_next;
          burst_void       <= burst_void_next;
          awaiting_second  <= awaiting_next;
          burst_start_time <= burst_start_next;
          first_clap_time  <= first_clap_next;
          clap_detected    <= clap_next;
          chunk_loud       <= loud;
        end
      end
    end
  end

  a_clap_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(clap_detected && chunk_loud))
    else $error("clap reported on a loud chunk");

  a_clap_ends_wait: assert property (@(posedge clk) disable iff (rst)
    (go && !chunk.clear && clap_next) |=> !awaiting_second && !in_burst)
    else $error("wait or burst survives a detected clap");

  a_clear_zeroes: assert property (@(posedge clk) disable iff (rst)
    (go && chunk.clear) |=> !in_burst && !awaiting_second && !burst_void
                            && (first_clap_time == '0))
    else $error("clear left burst state behind");

  a_loud_opens_burst: assert property (@(posedge clk) disable iff (rst)
    (go && !chunk.clear && loud) |=> in_burst && out_valid && chunk_loud)
    else $error("loud chunk did not open or keep a burst");

endmodule

/* hw/rtl/double_clap_detector.sv */
// channel  | role  | payload
// ---------+-------+-----------------------------------------------
// audio    | sink  | command, sample, chunk_end, now_ms
// result   | source| clap_detected, chunk_loud (per non-command chunk end)
// cfg      | sink  | index, data (always ready)
//
// One item per cycle while not stalled; a chunk-end item yields its result
// after square, accumulate, limit multiply and classify/burst into output.
// rst is synchronous: clears the pipeline, accumulators, burst state and
// restores register defaults. A stalled result holds only the stages behind
// it that are full; bubbles and clear items keep flowing.
module double_clap_detector (
  input  logic         clk,
  input  logic         rst,
  dcd_sample_if.sink   audio,
  dcd_result_if.source result,
  dcd_cfg_if.sink      cfg
);

  logic [dcd_pkg::CFG_W-1:0] rms_threshold;
  dcd_pkg::timing_t          timing;
  dcd_pkg::chunk_t           chunk;
  logic                      chunk_valid;
  logic                      chunk_ready;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rms_threshold      <= dcd_pkg::RMS_THRESHOLD_RST;
      timing.max_peak_ms <= dcd_pkg::MAX_PEAK_MS_RST;
      timing.window_ms   <= dcd_pkg::WINDOW_MS_RST;
      timing.min_gap_ms  <= dcd_pkg::MIN_GAP_MS_RST;
    end else if (cfg.valid) begin
      case (dcd_pkg::reg_idx_t'(cfg.index))
        dcd_pkg::REG_RMS_THRESHOLD: rms_threshold      <= cfg.data;
        dcd_pkg::REG_MAX_PEAK_MS:   timing.max_peak_ms <= cfg.data;
        dcd_pkg::REG_WINDOW_MS:     timing.window_ms   <= cfg.data;
        dcd_pkg::REG_MIN_GAP_MS:    timing.min_gap_ms  <= cfg.data;
        default: ;
      endcase
    end
  end

  dcd_energy u_energy (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (audio.valid),
    .in_ready      (audio.ready),
    .command       (audio.command),
    .sample        (audio.sample),
    .chunk_end     (audio.chunk_end),
    .now_ms        (audio.now_ms),
    .rms_threshold (rms_threshold),
    .chunk_valid   (chunk_valid),
    .chunk_ready   (chunk_ready),
    .chunk         (chunk)
  );

  dcd_burst u_burst (
    .clk           (clk),
    .rst           (rst),
    .timing        (timing),
    .chunk_valid   (chunk_valid),
    .chunk_ready   (chunk_ready),
    .chunk         (chunk),
    .out_valid     (result.valid),
    .out_ready     (result.ready),
    .clap_detected (result.clap_detected),
    .chunk_loud    (result.chunk_loud)
  );

endmodule
